### design/intel_hex_record_parser_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IHEX_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IHEX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ihex_pkg.sv
`timescale 1ns / 1ps
package ihex_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_FATAL  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_COLON  = 3'd1;
   localparam logic [2:0] ERR_BAD_CHAR  = 3'd2;
   localparam logic [2:0] ERR_LENGTH    = 3'd3;
   localparam logic [2:0] ERR_SEG_TYPE  = 3'd4;
   localparam logic [2:0] ERR_BAD_ELAR  = 3'd5;
   localparam logic [2:0] ERR_BAD_TYPE  = 3'd6;

   // record types
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;
   localparam logic [7:0] REC_ESAR = 8'h02;
   localparam logic [7:0] REC_SSAR = 8'h03;
   localparam logic [7:0] REC_ELAR = 8'h04;
   localparam logic [7:0] REC_SLAR = 8'h05;

   // characters
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

### design/intel_hex_record_parser_unit.sv
`timescale 1ns / 1ps
// Intel HEX record parser. Takes one character of hex file text per item and
// sustains one item per clock: all decoding for a character is done in one
// pass from the parser state into a single result register, so a character
// is accepted every cycle in which the result register is empty or its item
// is being taken. An accepted character's result is registered and presented
// in the cycle after it is accepted. A character yields at most one result: a data byte (record type 0,
// with its wrapped 16-bit address), a record status at CR or LF (length,
// checksum warning, type check, beyond-EOF warning), or a fatal error. After a
// fatal error, or a status with a nonzero error code, the parser swallows
// every character until reset; the consumer must drop that record's data
// bytes. Text after a CR is ignored up to and including the next LF. Lines
// longer than MAX_LINE_DIGITS hex digits stop counting there and are
// reported as a length error.
module intel_hex_record_parser_unit
   import ihex_pkg::*;
#(
   parameter int MAX_LINE_DIGITS = 1023
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_byte_address,
   output logic [7:0]  rsp_record_type,
   output logic [7:0]  rsp_record_length,
   output logic        rsp_checksum_bad,
   output logic        rsp_beyond_eof,
   output logic [2:0]  rsp_error_code
);

   // digit counter holds 0..MAX_LINE_DIGITS; $clog2(MAX_LINE_DIGITS + 1) bits, 10 by default
   localparam int CntW = $clog2(MAX_LINE_DIGITS + 1);

   typedef enum logic [1:0] {PH_COLON, PH_RECORD, PH_SKIP, PH_HALT} phase_type;

   phase_type         phase_ff, phase_in;
   logic [CntW-1:0]   digit_count_ff, digit_count_in;
   logic [3:0]        high_nibble_ff, high_nibble_in;
   logic [7:0]        length_ff, length_in;
   logic [15:0]       address_ff, address_in;
   logic [7:0]        type_ff, type_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        checksum_ff, checksum_in;
   logic              ext_nonzero_ff, ext_nonzero_in;
   logic              eof_seen_ff, eof_seen_in;

   logic              rsp_valid_ff;
   logic [1:0]        kind_ff, kind_in;
   logic [7:0]        data_ff, data_in;
   logic [15:0]       baddr_ff, baddr_in;
   logic [7:0]        rtype_ff, rtype_in;
   logic [7:0]        rlen_ff, rlen_in;
   logic              cbad_ff, cbad_in;
   logic              beof_ff, beof_in;
   logic [2:0]        err_ff, err_in;

   logic              accept;
   logic              emit;
   hex_digit_type     hd;
   logic [7:0]        byte_val;
   logic [CntW-1:0]   byte_idx;      // byte position within the line
   logic [CntW-1:0]   ck_pos;        // position of the checksum byte
   logic [CntW-1:0]   want_digits;   // (length + 5) * 2
   logic              in_body;
   logic              len_ok;
   logic [2:0]        end_err;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign hd        = hex_decode(req_char_in);

   assign byte_val    = {high_nibble_ff, hd.value};
   assign byte_idx    = CntW'(digit_count_ff[CntW-1:1]);
   assign ck_pos      = CntW'({1'b0, length_ff} + 9'd4);
   assign in_body     = byte_idx < ck_pos;
   assign want_digits = CntW'({({1'b0, length_ff} + 9'd5), 1'b0});
   assign len_ok      = want_digits == digit_count_ff;

   // record length and type check at line end
   always_comb begin
      end_err = ERR_NONE;
      if (!len_ok) begin
         end_err = ERR_LENGTH;
      end else begin
         case (type_ff)
            REC_DATA, REC_EOF:            end_err = ERR_NONE;
            REC_ESAR, REC_SSAR, REC_SLAR: end_err = ERR_SEG_TYPE;
            REC_ELAR: begin
               if (length_ff < 8'd2 || ext_nonzero_ff) end_err = ERR_BAD_ELAR;
            end
            default:                      end_err = ERR_BAD_TYPE;
         endcase
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      high_nibble_in = high_nibble_ff;
      length_in      = length_ff;
      address_in     = address_ff;
      type_in        = type_ff;
      sum_in         = sum_ff;
      checksum_in    = checksum_ff;
      ext_nonzero_in = ext_nonzero_ff;
      eof_seen_in    = eof_seen_ff;

      emit     = 1'b0;
      kind_in  = KIND_DATA;
      data_in  = 8'd0;
      baddr_in = 16'd0;
      rtype_in = 8'd0;
      rlen_in  = 8'd0;
      cbad_in  = 1'b0;
      beof_in  = eof_seen_ff;
      err_in   = ERR_NONE;

      if (accept) begin
         case (phase_ff)
            PH_HALT: ;
            PH_SKIP: begin
               if (req_char_in == CHAR_LF) phase_in = PH_COLON;
            end
            PH_COLON: begin
               if (req_char_in != CHAR_COLON) begin
                  emit     = 1'b1;
                  kind_in  = KIND_FATAL;
                  err_in   = ERR_NO_COLON;
                  phase_in = PH_HALT;
               end else begin
                  phase_in       = PH_RECORD;
                  digit_count_in = '0;
                  high_nibble_in = 4'd0;
                  length_in      = 8'd0;
                  address_in     = 16'd0;
                  type_in        = 8'd0;
                  sum_in         = 8'd0;
                  checksum_in    = 8'd0;
                  ext_nonzero_in = 1'b0;
               end
            end
            PH_RECORD: begin
               if (req_char_in == CHAR_CR || req_char_in == CHAR_LF) begin
                  emit     = 1'b1;
                  kind_in  = KIND_STATUS;
                  rtype_in = type_ff;
                  rlen_in  = length_ff;
                  cbad_in  = len_ok && ((8'd0 - sum_ff) != checksum_ff);
                  err_in   = end_err;
                  if (end_err == ERR_NONE && type_ff == REC_EOF) eof_seen_in = 1'b1;
                  if (end_err != ERR_NONE) phase_in = PH_HALT;
                  else if (req_char_in == CHAR_CR) phase_in = PH_SKIP;
                  else phase_in = PH_COLON;
               end else if (!hd.valid) begin
                  emit     = 1'b1;
                  kind_in  = KIND_FATAL;
                  err_in   = ERR_BAD_CHAR;
                  phase_in = PH_HALT;
               end else if (digit_count_ff < CntW'(MAX_LINE_DIGITS)) begin
                  digit_count_in = digit_count_ff + CntW'(1);
                  if (!digit_count_ff[0]) begin
                     high_nibble_in = hd.value;
                  end else begin
                     if (in_body) sum_in = sum_ff + byte_val;
                     if (byte_idx == CntW'(0)) begin
                        length_in = byte_val;
                     end else if (byte_idx == CntW'(1)) begin
                        address_in = {byte_val, address_ff[7:0]};
                     end else if (byte_idx == CntW'(2)) begin
                        address_in = {address_ff[15:8], byte_val};
                     end else if (byte_idx == CntW'(3)) begin
                        type_in = byte_val;
                     end else if (in_body) begin
                        if (type_ff == REC_ELAR && byte_idx < CntW'(6) && byte_val != 8'd0)
                           ext_nonzero_in = 1'b1;
                        if (type_ff == REC_DATA) begin
                           emit       = 1'b1;
                           kind_in    = KIND_DATA;
                           data_in    = byte_val;
                           baddr_in   = address_ff;
                           rlen_in    = length_ff;
                           address_in = address_ff + 16'd1;
                        end
                     end else if (byte_idx == ck_pos) begin
                        checksum_in = byte_val;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COLON;
         digit_count_ff <= '0;
         high_nibble_ff <= 4'd0;
         length_ff      <= 8'd0;
         address_ff     <= 16'd0;
         type_ff        <= 8'd0;
         sum_ff         <= 8'd0;
         checksum_ff    <= 8'd0;
         ext_nonzero_ff <= 1'b0;
         eof_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         high_nibble_ff <= high_nibble_in;
         length_ff      <= length_in;
         address_ff     <= address_in;
         type_ff        <= type_in;
         sum_ff         <= sum_in;
         checksum_ff    <= checksum_in;
         ext_nonzero_ff <= ext_nonzero_in;
         eof_seen_ff    <= eof_seen_in;
         if (accept) rsp_valid_ff <= emit;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         // result payload, no reset needed
         if (accept && emit) begin
            kind_ff  <= kind_in;
            data_ff  <= data_in;
            baddr_ff <= baddr_in;
            rtype_ff <= rtype_in;
            rlen_ff  <= rlen_in;
            cbad_ff  <= cbad_in;
            beof_ff  <= beof_in;
            err_ff   <= err_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_address  = baddr_ff;
   assign rsp_record_type   = rtype_ff;
   assign rsp_record_length = rlen_ff;
   assign rsp_checksum_bad  = cbad_ff;
   assign rsp_beyond_eof    = beof_ff;
   assign rsp_error_code    = err_ff;

endmodule

### design/ihex_checker.sv
`timescale 1ns / 1ps
`include "intel_hex_record_parser_unit_macros.svh"
module ihex_checker
   import ihex_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_byte_address,
   input logic [7:0]  rsp_record_type,
   input logic [7:0]  rsp_record_length,
   input logic        rsp_checksum_bad,
   input logic        rsp_beyond_eof,
   input logic [2:0]  rsp_error_code
);

   logic [46:0] rsp_payload;
   logic        rsp_stall;
   logic        data_clean;

   assign rsp_payload = {rsp_kind, rsp_data_byte, rsp_byte_address, rsp_record_type,
                         rsp_record_length, rsp_checksum_bad, rsp_beyond_eof,
                         rsp_error_code};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign data_clean  = rsp_error_code == ERR_NONE && rsp_record_type == 8'd0 &&
                        !rsp_checksum_bad;

   // a stalled result keeps its payload
   `IHEX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload), "rsp item changed while stalled")

   // nothing comes out after a fatal item is taken
   `IHEX_ASSERT_NEXT(a_halt_after_fatal, clock, reset, rsp_valid && rsp_ready && rsp_kind == KIND_FATAL, !rsp_valid, "result after fatal error")

   // data bytes carry no error, no checksum flag and record type 0
   `IHEX_ASSERT_NOW(a_data_clean, clock, reset, rsp_valid && rsp_kind == KIND_DATA, data_clean, "data item with status fields set")

   // fatal errors come only from framing or bad characters
   `IHEX_ASSERT_NOW(a_fatal_code, clock, reset, rsp_valid && rsp_kind == KIND_FATAL, rsp_error_code == ERR_NO_COLON || rsp_error_code == ERR_BAD_CHAR, "fatal item with wrong error code")

   // a length error suppresses the checksum warning
   `IHEX_ASSERT_NOW(a_len_no_cbad, clock, reset, rsp_valid && rsp_kind == KIND_STATUS && rsp_error_code == ERR_LENGTH, !rsp_checksum_bad, "checksum flag on length error")

endmodule

bind intel_hex_record_parser_unit ihex_checker u_ihex_checker (.*);

### dv/tb_intel_hex_record_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for the Intel HEX record parser.
module tb_intel_hex_record_parser_unit;
   import ihex_pkg::*;

   localparam int LINE_DIGIT_LIMIT = 522;
   localparam int TIMEOUT_CYCLES   = 400000;
   localparam int RANDOM_CHARS     = 470;

   typedef bit [7:0] octet_q_type[$];

   // One result item as the block presents it.
   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_address;
      logic [7:0]  record_type;
      logic [7:0]  record_length;
      logic        checksum_bad;
      logic        beyond_eof;
      logic [2:0]  error_code;
   } hex_result_type;

   // Line parser predictor plus the queue of results it has promised.
   class hex_record_scoreboard;
      typedef enum logic [1:0] {AWAIT_COLON, IN_RECORD, SKIP_TO_LF, HALTED} parse_phase_type;

      int               digit_limit;
      parse_phase_type  phase;
      int unsigned      digits;
      bit [3:0]         hi_nib;
      bit [7:0]         decl_len;
      bit [15:0]        load_addr;
      bit [7:0]         rec_type;
      bit [7:0]         sum;
      bit [7:0]         stored_sum;
      bit               ext_nz;
      bit               eof_seen;
      hex_result_type   pending_results[$];
      int unsigned      fail_count;

      function new(int limit);
         digit_limit = limit;
         phase       = AWAIT_COLON;
         digits      = 0;
         hi_nib      = '0;
         decl_len    = '0;
         load_addr   = '0;
         rec_type    = '0;
         sum         = '0;
         stored_sum  = '0;
         ext_nz      = 1'b0;
         eof_seen    = 1'b0;
         fail_count  = 0;
      endfunction

      function void push(logic [1:0] kind, logic [7:0] data, logic [15:0] addr,
                         logic [7:0] rtype, logic [7:0] rlen, logic cbad, logic [2:0] err);
         hex_result_type r;
         r.kind          = kind;
         r.data_byte     = data;
         r.byte_address  = addr;
         r.record_type   = rtype;
         r.record_length = rlen;
         r.checksum_bad  = cbad;
         r.beyond_eof    = eof_seen;
         r.error_code    = err;
         pending_results.push_back(r);
      endfunction

      function void halt_with(logic [2:0] err);
         push(KIND_FATAL, 8'd0, 16'd0, 8'd0, 8'd0, 1'b0, err);
         phase = HALTED;
      endfunction

      function int nibble_of(bit [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function void add_digit(bit [3:0] v);
         int unsigned pos;
         int unsigned k;
         int unsigned len;
         bit [7:0]    b;
         if (digits >= digit_limit) return;   // overlong line: stop counting
         pos = digits;
         digits++;
         if (!pos[0]) begin
            hi_nib = v;
            return;
         end
         b   = {hi_nib, v};
         k   = pos >> 1;
         len = decl_len;
         if (k < 4 + len) sum += b;           // checksum byte itself not summed
         if (k == 0) begin
            decl_len = b;
         end else if (k == 1) begin
            load_addr[15:8] = b;
         end else if (k == 2) begin
            load_addr[7:0] = b;
         end else if (k == 3) begin
            rec_type = b;
         end else if (k < 4 + len) begin
            if (rec_type == REC_ELAR && k < 6 && b != 8'd0) ext_nz = 1'b1;
            if (rec_type == REC_DATA) begin
               push(KIND_DATA, b, load_addr, 8'd0, decl_len, 1'b0, ERR_NONE);
               load_addr++;
            end
         end else if (k == 4 + len) begin
            stored_sum = b;
         end
      endfunction

      function void close_line(bit after_cr);
         logic [2:0] err;
         bit         cbad;
         bit [7:0]   want;
         err  = ERR_NONE;
         cbad = 1'b0;
         if ((int'(decl_len) + 5) * 2 != digits) begin
            err = ERR_LENGTH;
         end else begin
            want = 8'd0 - sum;
            cbad = (want != stored_sum);
            case (rec_type)
               REC_DATA, REC_EOF: ;
               REC_ESAR, REC_SSAR, REC_SLAR: err = ERR_SEG_TYPE;
               REC_ELAR: if (decl_len < 2 || ext_nz) err = ERR_BAD_ELAR;
               default: err = ERR_BAD_TYPE;
            endcase
         end
         push(KIND_STATUS, 8'd0, 16'd0, rec_type, decl_len, cbad, err);
         if (err == ERR_NONE && rec_type == REC_EOF) eof_seen = 1'b1;
         if (err != ERR_NONE) phase = HALTED;
         else phase = after_cr ? SKIP_TO_LF : AWAIT_COLON;
      endfunction

      function void note_char(bit [7:0] c);
         int v;
         case (phase)
            HALTED: ;
            SKIP_TO_LF: if (c == CHAR_LF) phase = AWAIT_COLON;
            AWAIT_COLON: begin
               if (c != CHAR_COLON) begin
                  halt_with(ERR_NO_COLON);
               end else begin
                  phase      = IN_RECORD;
                  digits     = 0;
                  hi_nib     = '0;
                  decl_len   = '0;
                  load_addr  = '0;
                  rec_type   = '0;
                  sum        = '0;
                  stored_sum = '0;
                  ext_nz     = 1'b0;
               end
            end
            default: begin
               if (c == CHAR_CR) begin
                  close_line(1'b1);
               end else if (c == CHAR_LF) begin
                  close_line(1'b0);
               end else begin
                  v = nibble_of(c);
                  if (v < 0) halt_with(ERR_BAD_CHAR);
                  else add_digit(v[3:0]);
               end
            end
         endcase
      endfunction

      function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_result(hex_result_type got);
         hex_result_type exp;
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected (kind %0d)", got.kind);
            fail_count++;
            return;
         end
         exp = pending_results.pop_front();
         cmp_field("kind",          exp.kind,          got.kind);
         cmp_field("data_byte",     exp.data_byte,     got.data_byte);
         cmp_field("byte_address",  exp.byte_address,  got.byte_address);
         cmp_field("record_type",   exp.record_type,   got.record_type);
         cmp_field("record_length", exp.record_length, got.record_length);
         cmp_field("checksum_bad",  exp.checksum_bad,  got.checksum_bad);
         cmp_field("beyond_eof",    exp.beyond_eof,    got.beyond_eof);
         cmp_field("error_code",    exp.error_code,    got.error_code);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_byte_address;
   logic [7:0]  rsp_record_type;
   logic [7:0]  rsp_record_length;
   logic        rsp_checksum_bad;
   logic        rsp_beyond_eof;
   logic [2:0]  rsp_error_code;

   hex_record_scoreboard sb;
   bit          idle_on;      // sender gaps enabled
   bit          stall_on;     // receiver stalls enabled
   int unsigned chars_sent;
   int unsigned cycle_count;

   intel_hex_record_parser_unit #(
      .MAX_LINE_DIGITS(LINE_DIGIT_LIMIT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_byte_address(rsp_byte_address),
      .rsp_record_type(rsp_record_type),
      .rsp_record_length(rsp_record_length),
      .rsp_checksum_bad(rsp_checksum_bad),
      .rsp_beyond_eof(rsp_beyond_eof),
      .rsp_error_code(rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("FAIL intel_hex_record_parser_unit");
         $finish;
      end
   end

   // Monitor: both channels sampled at the edge, so values are pre-update.
   // An accepted char feeds the predictor before any result is checked; a
   // char's own result cannot appear at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_char(req_char_in);
         if (rsp_valid && rsp_ready)
            sb.check_result('{rsp_kind, rsp_data_byte, rsp_byte_address, rsp_record_type,
                              rsp_record_length, rsp_checksum_bad, rsp_beyond_eof,
                              rsp_error_code});
      end
   end

   // Receiver back-pressure: random stall bursts while enabled.
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   function automatic bit [7:0] hex_digit(input bit [3:0] n, input bit upper);
      if (n < 10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   function automatic octet_q_type random_body(input int n);
      octet_q_type q;
      repeat (n) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // One char item; an optional idle gap goes ahead of it.
   task automatic send_char(input bit [7:0] c);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_ready);
      chars_sent++;
   endtask

   task automatic send_hex_byte(input bit [7:0] b);
      send_char(hex_digit(b[7:4], 1'($urandom_range(0, 1))));
      send_char(hex_digit(b[3:0], 1'($urandom_range(0, 1))));
   endtask

   // Full record line. extra_digits pads hex digits after the checksum
   // (length-error cases); a CR ending is followed by junk and then LF.
   task automatic send_record(input bit [7:0] rtype, input bit [15:0] addr,
                              input octet_q_type body, input bit bad_sum,
                              input int extra_digits, input bit use_cr);
      bit [7:0] len;
      bit [7:0] sum;
      bit [7:0] junk;
      len = 8'(body.size());
      sum = len + addr[15:8] + addr[7:0] + rtype;
      foreach (body[i]) sum += body[i];
      sum = 8'd0 - sum;
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      send_char(CHAR_COLON);
      send_hex_byte(len);
      send_hex_byte(addr[15:8]);
      send_hex_byte(addr[7:0]);
      send_hex_byte(rtype);
      foreach (body[i]) send_hex_byte(body[i]);
      send_hex_byte(sum);
      repeat (extra_digits) send_char(hex_digit(4'($urandom_range(0, 15)), 1'b1));
      if (use_cr) begin
         send_char(CHAR_CR);
         // anything but LF is skipped after CR, so all byte values go here
         repeat ($urandom_range(0, 4)) begin
            do junk = 8'($urandom_range(0, 255)); while (junk == CHAR_LF);
            send_char(junk);
         end
      end
      send_char(CHAR_LF);
   endtask

   initial begin
      octet_q_type body;
      bit [7:0]    c;
      bit [7:0]    rt;
      bit [15:0]   addr;
      int unsigned budget_end;
      int          sel;
      int          len;

      sb          = new(LINE_DIGIT_LIMIT);
      idle_on     = 1'b0;
      stall_on    = 1'b0;
      chars_sent  = 0;
      req_valid   <= 1'b0;
      req_char_in <= 8'd0;
      reset       <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: address wrap past FFFF with extreme data values and a CR
      // line end; a valid extended linear address; an empty data record
      // with a bad checksum (warning only).
      body = '{8'hFF, 8'h00};
      send_record(REC_DATA, 16'hFFFF, body, 1'b0, 0, 1'b1);
      body = '{8'h00, 8'h00};
      send_record(REC_ELAR, 16'h0000, body, 1'b0, 0, 1'b0);
      body = {};
      send_record(REC_DATA, 16'h0000, body, 1'b1, 0, 1'b0);

      // Random well-formed records. Gaps and stalls toggle per record so
      // some stretches run at full rate. End-of-file records only show up
      // in the second half so beyond_eof is seen both ways.
      budget_end = chars_sent + RANDOM_CHARS;
      while (chars_sent < budget_end) begin
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         addr     = 16'($urandom_range(0, 65535));
         sel      = $urandom_range(0, 15);
         if (sel >= 15 && chars_sent > budget_end - RANDOM_CHARS / 2) begin
            body = random_body($urandom_range(0, 2));
            rt   = REC_EOF;
         end else if (sel >= 13) begin
            body    = random_body($urandom_range(2, 5));
            body[0] = 8'h00;
            body[1] = 8'h00;
            rt      = REC_ELAR;
         end else begin
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            body = random_body(len);
            rt   = REC_DATA;
            if ($urandom_range(0, 4) == 0) addr = 16'hFFFF - 16'($urandom_range(0, 3));
         end
         send_record(rt, addr, body, ($urandom_range(0, 3) == 0), 0,
                     1'($urandom_range(0, 1)));
      end

      // Closing part at full rate: one randomly chosen error case or a clean
      // finish, then after an error characters that the halted block must swallow.
      idle_on  = 1'b0;
      stall_on = 1'b0;
      addr     = 16'($urandom_range(0, 65535));
      sel      = $urandom_range(0, 8);
      case (sel)
         0: begin   // no colon at line start
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON);
            send_char(c);
         end
         1: begin   // non-hex char inside a record, NUL included
            send_char(CHAR_COLON);
            repeat ($urandom_range(0, 9)) send_char(hex_digit(4'($urandom_range(0, 15)), 1'b0));
            do c = 8'($urandom_range(0, 255));
            while (sb.nibble_of(c) >= 0 || c == CHAR_CR || c == CHAR_LF);
            send_char(c);
         end
         2: begin   // digits after the checksum: odd count or an extra byte
            send_record(REC_DATA, addr, random_body($urandom_range(0, 4)), 1'b0,
                        $urandom_range(1, 3), 1'($urandom_range(0, 1)));
         end
         3: begin   // fewer than two digits
            send_char(CHAR_COLON);
            repeat ($urandom_range(0, 1)) send_char(hex_digit(4'($urandom_range(0, 15)), 1'b1));
            send_char(CHAR_LF);
         end
         4: begin   // overlong line, digit count saturates
            send_char(CHAR_COLON);
            repeat (LINE_DIGIT_LIMIT + $urandom_range(1, 20))
               send_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            send_char(CHAR_LF);
         end
         5: begin   // segment address records are rejected
            case ($urandom_range(0, 2))
               0: rt = REC_ESAR;
               1: rt = REC_SSAR;
               default: rt = REC_SLAR;
            endcase
            send_record(rt, addr, random_body($urandom_range(0, 4)), 1'b0, 0, 1'b0);
         end
         6: begin   // extended linear address too short or nonzero
            if ($urandom_range(0, 1) == 0) begin
               body = random_body($urandom_range(0, 1));
            end else begin
               body = random_body($urandom_range(2, 4));
               body[$urandom_range(0, 1)] = 8'($urandom_range(1, 255));
            end
            send_record(REC_ELAR, addr, body, 1'b0, 0, 1'b0);
         end
         7: begin   // unknown record type
            send_record(8'($urandom_range(6, 255)), addr, random_body($urandom_range(0, 4)),
                        1'b0, 0, 1'b0);
         end
         default: begin   // clean finish on a maximum-length data record
            send_record(REC_DATA, addr, random_body(255), 1'b0, 0, 1'($urandom_range(0, 1)));
         end
      endcase
      if (sel != 8) repeat (20) send_char(8'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      // Drain: let the monitor catch up, wait out expected results, then
      // wait on so that anything unexpected still has time to show.
      repeat (2) @(posedge clock);
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending_results.size() != 0)
         $error("%0d expected result items never arrived", sb.pending_results.size());
      if (sb.fail_count == 0 && sb.pending_results.size() == 0) begin
         $display("PASS intel_hex_record_parser_unit");
      end else begin
         $display("FAIL intel_hex_record_parser_unit");
      end
      $finish;
   end

endmodule
